// ===== sv/utfst_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utfst_pkg
// Shared types, constants and the lead byte decoder of the utf-8 sanitizer.
// ----------------------------------------------------------------------------
package utfst_pkg;

  localparam int unsigned LimitW     = 12;
  localparam logic [LimitW-1:0] LimitReset = 12'd256;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned MaxOut     = 4;

  localparam logic [7:0] Qmark   = 8'h3F;
  localparam logic [7:0] CtrlTop = 8'h20;
  localparam logic [7:0] DelChar = 8'h7F;
  localparam logic [7:0] ContLo  = 8'h80;
  localparam logic [7:0] ContHi  = 8'hBF;
  localparam logic [7:0] Lead2Lo = 8'hC2;
  localparam logic [7:0] Lead2Hi = 8'hDF;
  localparam logic [7:0] Lead3Lo = 8'hE0;
  localparam logic [7:0] Lead3Hi = 8'hEF;
  localparam logic [7:0] Lead4Lo = 8'hF0;
  localparam logic [7:0] Lead4Hi = 8'hF4;
  localparam logic [7:0] LeadSurr = 8'hED;
  localparam logic [7:0] SecE0Min = 8'hA0;
  localparam logic [7:0] SecEDMax = 8'h9F;
  localparam logic [7:0] SecF0Min = 8'h90;
  localparam logic [7:0] SecF4Max = 8'h8F;

  // results caused by one input item, in output order
  typedef struct packed {
    logic [2:0]            n;
    logic [MaxOut-1:0][7:0] bytes;
    logic                  last;
    logic                  truncated;
    logic                  sanitized;
  } utfst_group_t;

  // length announced by a lead byte, 0 for a byte that cannot start a sequence
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if (b < ContLo) begin
      len = 3'd1;
    end else if (b >= Lead2Lo && b <= Lead2Hi) begin
      len = 3'd2;
    end else if (b >= Lead3Lo && b <= Lead3Hi) begin
      len = 3'd3;
    end else if (b >= Lead4Lo && b <= Lead4Hi) begin
      len = 3'd4;
    end
    return len;
  endfunction

endpackage
`default_nettype wire

// ===== sv/utfst_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utfst channel interfaces
// Valid/ready channels for raw bytes, result items and the limit register.
// ----------------------------------------------------------------------------
interface utfst_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, in_byte, in_last, input ready);
  modport sink (input valid, in_byte, in_last, output ready);
endinterface

interface utfst_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       out_last;
  logic       truncated;
  logic       sanitized;
  modport source (output valid, out_byte, has_byte, out_last, truncated, sanitized,
                  input ready);
  modport sink (input valid, out_byte, has_byte, out_last, truncated, sanitized,
                output ready);
endinterface

interface utfst_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [utfst_pkg::LimitW-1:0] byte_limit;
  modport source (output valid, byte_limit, input ready);
  modport sink (input valid, byte_limit, output ready);
endinterface
`default_nettype wire

// ===== sv/utfst_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utfst_front
// Decodes one byte per cycle while the queue has room, tracks the open
// sequence and limit, and pushes each item's results as one queue group.
// ----------------------------------------------------------------------------
module utfst_front (
  input  logic                    clk,
  input  logic                    rst,
  utfst_in_if.sink                rx,
  utfst_cfg_if.sink               cfg,
  input  logic                    full,
  output logic                    push,
  output utfst_pkg::utfst_group_t group
);
  import utfst_pkg::*;

  logic [LimitW-1:0] limit;
  logic [2:0][7:0]   pend;
  logic [1:0]        pc;
  logic [2:0]        sl;
  logic [LimitW-1:0] wc;
  logic              cut;
  logic              repl;
  logic              stopped;

  logic              accept;
  logic [7:0]        c;
  logic              is_cont;
  logic              is_ctrl;
  logic [2:0]        flen;
  logic [3:0][7:0]   seq;
  logic [3:0][7:0]   chunk;
  logic [7:0]        second;
  logic              seq_ok;
  logic [2:0]        q;
  logic [2:0]        chunk_len;
  logic              fresh;
  logic              ascii;
  logic [1:0]        pc_mid;
  logic [2:0]        sl_mid;
  logic              pend_we;
  logic [1:0]        pend_idx;
  logic [LimitW-1:0] avail;
  logic [LimitW-1:0] avail2;
  logic              q_fits;
  logic              chunk_fits;
  logic              emit_chunk;
  logic              hit;
  logic [2:0]        kq;
  logic [2:0]        n;
  logic [2:0]        j;

  assign accept  = rx.valid && rx.ready;
  assign rx.ready = !full;
  assign cfg.ready = 1'b1;
  assign c       = rx.in_byte;
  assign is_cont = (c >= ContLo) && (c <= ContHi);
  assign is_ctrl = (c < CtrlTop) || (c == DelChar);
  assign flen    = lead_length(c);

  // the sequence as it stands once this byte is added
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      seq[i] = (pc == 2'(i)) ? c : pend[i];
    end
    seq[3] = c;
  end

  assign second = (pc == 2'd1) ? c : pend[1];
  assign seq_ok = !((pend[0] == Lead3Lo  && second < SecE0Min) ||
                    (pend[0] == LeadSurr && second > SecEDMax) ||
                    (pend[0] == Lead4Lo  && second < SecF0Min) ||
                    (pend[0] == Lead4Hi  && second > SecF4Max));

  // replacements first, then at most one whole chunk of kept bytes
  always_comb begin
    q         = 3'd0;
    chunk_len = 3'd0;
    fresh     = 1'b0;
    ascii     = 1'b0;
    pc_mid    = pc;
    sl_mid    = sl;
    pend_we   = 1'b0;
    pend_idx  = pc;
    if (!stopped) begin
      if (pc == 2'd0) begin
        fresh = 1'b1;
      end else if (!is_cont) begin
        q      = {1'b0, pc};
        pc_mid = 2'd0;
        sl_mid = 3'd0;
        fresh  = 1'b1;
      end else if (({1'b0, pc} + 3'd1) < sl) begin
        pend_we = 1'b1;
        pc_mid  = pc + 2'd1;
      end else begin
        pc_mid = 2'd0;
        sl_mid = 3'd0;
        if (seq_ok) begin
          chunk_len = sl;
        end else begin
          q = sl;
        end
      end
      if (fresh) begin
        if (is_ctrl || flen == 3'd0) begin
          q = q + 3'd1;
        end else if (flen == 3'd1) begin
          chunk_len = 3'd1;
          ascii     = 1'b1;
        end else begin
          pend_we  = 1'b1;
          pend_idx = 2'd0;
          pc_mid   = 2'd1;
          sl_mid   = flen;
        end
      end
      // unfinished sequence at the end of the string
      if (rx.in_last && pc_mid != 2'd0) begin
        q = q + {1'b0, pc_mid};
      end
    end
  end

  assign chunk = ascii ? {24'd0, c} : seq;

  assign avail      = (wc >= limit) ? '0 : (limit - wc);
  assign q_fits     = {{(LimitW-3){1'b0}}, q} <= avail;
  assign avail2     = avail - {{(LimitW-3){1'b0}}, q};
  assign chunk_fits = {{(LimitW-3){1'b0}}, chunk_len} <= avail2;
  assign emit_chunk = q_fits && chunk_fits && (chunk_len != 3'd0);
  assign hit        = !q_fits || ((chunk_len != 3'd0) && !chunk_fits);
  assign kq         = q_fits ? q : avail[2:0];
  assign n          = kq + (emit_chunk ? chunk_len : 3'd0);

  always_comb begin
    group.n         = n;
    group.last      = rx.in_last;
    group.truncated = rx.in_last && (cut || hit);
    group.sanitized = rx.in_last && (repl || kq != 3'd0);
    for (int i = 0; i < MaxOut; i++) begin
      j = 3'(i) - kq;
      group.bytes[i] = (3'(i) < kq) ? Qmark : chunk[j[1:0]];
    end
  end

  assign push = accept && (n != 3'd0 || rx.in_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LimitReset;
    end else if (cfg.valid) begin
      limit <= cfg.byte_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc      <= '0;
      sl      <= '0;
      wc      <= '0;
      cut     <= 1'b0;
      repl    <= 1'b0;
      stopped <= 1'b0;
    end else if (accept) begin
      if (rx.in_last) begin
        pc      <= '0;
        sl      <= '0;
        wc      <= '0;
        cut     <= 1'b0;
        repl    <= 1'b0;
        stopped <= 1'b0;
      end else begin
        pc      <= pc_mid;
        sl      <= sl_mid;
        wc      <= wc + {{(LimitW-3){1'b0}}, n};
        cut     <= cut || hit;
        repl    <= repl || (kq != 3'd0);
        stopped <= stopped || hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && pend_we) begin
      pend[pend_idx] <= c;
    end
  end

`ifndef SYNTHESIS
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    accept && rx.in_last |=> (pc == 2'd0 && wc == '0 && !stopped && !cut && !repl))
    else $error("string state not cleared after last item");
  a_open_seq_shape: assert property (@(posedge clk) disable iff (rst)
    pc != 2'd0 |-> ({1'b0, pc} < sl && sl <= 3'd4))
    else $error("open sequence count out of range");
  a_no_output_when_stopped: assert property (@(posedge clk) disable iff (rst)
    stopped |-> n == 3'd0)
    else $error("output produced after limit stop");
`endif

endmodule
`default_nettype wire

// ===== sv/utfst_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utfst_queue
// Short queue of result groups between the decoder and the output stage.
// ----------------------------------------------------------------------------
module utfst_queue #(
  parameter int unsigned Depth = utfst_pkg::QueueDepth
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  utfst_pkg::utfst_group_t wr_group,
  input  logic                    pop,
  output utfst_pkg::utfst_group_t head,
  output logic                    full,
  output logic                    empty
);
  import utfst_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  utfst_group_t       mem [Depth];
  logic [PtrW-1:0]    wr_ptr;
  logic [PtrW-1:0]    rd_ptr;
  logic [CntW-1:0]    count;

  assign full  = (count == CntW'(Depth));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_group;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full || pop)
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("queue underflow");
`endif

endmodule
`default_nettype wire

// ===== sv/utfst_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utfst_back
// Unpacks each result group into single items on a registered output.
// ----------------------------------------------------------------------------
module utfst_back (
  input  logic                    clk,
  input  logic                    rst,
  input  utfst_pkg::utfst_group_t head,
  input  logic                    empty,
  output logic                    pop,
  utfst_out_if.source             tx
);
  import utfst_pkg::*;

  logic [1:0] k;
  logic [1:0] last_idx;
  logic       load;
  logic       at_end;
  logic       has;

  // a status-only group still makes one item
  assign has      = (head.n != 3'd0);
  assign last_idx = has ? 2'(head.n - 3'd1) : 2'd0;
  assign at_end   = (k == last_idx);
  assign load     = !empty && (!tx.valid || tx.ready);
  assign pop      = load && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      tx.valid <= 1'b0;
      k        <= '0;
    end else if (load) begin
      tx.valid <= 1'b1;
      k        <= at_end ? 2'd0 : k + 2'd1;
    end else if (tx.ready) begin
      tx.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tx.out_byte  <= has ? head.bytes[k] : 8'd0;
      tx.has_byte  <= has;
      tx.out_last  <= head.last && at_end;
      tx.truncated <= head.truncated && at_end;
      tx.sanitized <= head.sanitized && at_end;
    end
  end

`ifndef SYNTHESIS
  a_flags_on_last: assert property (@(posedge clk) disable iff (rst)
    tx.valid && (tx.truncated || tx.sanitized || !tx.has_byte) |-> tx.out_last)
    else $error("status on an item that does not close the string");
`endif

endmodule
`default_nettype wire

// ===== sv/utf8_sanitize_truncate_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_sanitize_truncate_core
// UTF-8 sanitizer with a per-string output byte limit.
// ----------------------------------------------------------------------------
// rx carries raw string bytes, one item per byte, in_last on the final byte.
// tx carries result items: a kept byte or '?' with has_byte set, and on the
// final item of each string out_last with the truncated and sanitized flags
// (a status-only item with has_byte clear when the last byte yields nothing).
// cfg writes byte_limit (reset 256); it is always ready and is meant to be
// written between strings.
// The decoder takes one byte per cycle while the group queue has room; each
// byte makes up to four items, sent one per cycle while tx is ready.
// Items go through the queue memory and the output register. Sustained
// rate is one byte per cycle unless the items of a byte outnumber the bytes,
// as at a broken sequence, when the output stage at one item per cycle sets
// the pace and the queue of QDepth groups absorbs the burst.
// A stalled tx holds its item; the queue fills and rx.ready drops.
// Synchronous reset clears the string state, the queue and the output valid.
// ----------------------------------------------------------------------------
module utf8_sanitize_truncate_core #(
  parameter int unsigned QDepth = utfst_pkg::QueueDepth
) (
  input  logic         clk,
  input  logic         rst,
  utfst_in_if.sink     rx,
  utfst_out_if.source  tx,
  utfst_cfg_if.sink    cfg
);
  import utfst_pkg::*;

  utfst_group_t wr_group;
  utfst_group_t head;
  logic         push;
  logic         pop;
  logic         full;
  logic         empty;

  utfst_front u_front (
    .clk   (clk),
    .rst   (rst),
    .rx    (rx),
    .cfg   (cfg),
    .full  (full),
    .push  (push),
    .group (wr_group)
  );

  utfst_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_group (wr_group),
    .pop      (pop),
    .head     (head),
    .full     (full),
    .empty    (empty)
  );

  utfst_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .empty (empty),
    .pop   (pop),
    .tx    (tx)
  );

endmodule
`default_nettype wire
